[hdl/hwp_pkg.sv]
// ----------------------------------------------------------------------------
// hwp_pkg
// Types, codes and helpers shared by the hex word text parser modules.
// ----------------------------------------------------------------------------
package hwp_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_WORD       = 2'd0,
    ST_NON_ASCII  = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_INVALID    = 2'd3
  } status_e;

  // input beat
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_data;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [31:0] word;
    status_e     status;
  } out_beat_t;

  // handshake between the input register and the parser core
  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } item_t;

  // result handed from the core to the output register
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } result_t;

  // character codes
  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChHt   = 8'h09;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChVt   = 8'h0B;
  localparam logic [7:0] ChFf   = 8'h0C;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChSpc  = 8'h20;
  localparam logic [7:0] ChHash = 8'h23;

  // hex digit decode: bit 4 flags a digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  // blanks skipped between words
  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpc) || (c == ChHt) || (c == ChVt) || (c == ChFf) || (c == ChCr);
  endfunction

endpackage

[hdl/hwp_in_reg.sv]
// ----------------------------------------------------------------------------
// hwp_in_reg
// Input register: holds one beat until the parser core takes it.
// ----------------------------------------------------------------------------
module hwp_in_reg import hwp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_beat_t in_beat_i,
  input  logic     take_i,
  output item_t    item_o
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;
  logic     load;

  // free when empty or when the held beat moves on this cycle
  assign load       = !valid_q || take_i;
  assign in_stall_o = !load;
  assign valid_d    = load ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      beat_q <= in_beat_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.beat  = beat_q;

endmodule

[hdl/hwp_core.sv]
// ----------------------------------------------------------------------------
// hwp_core
// Parser state and the per-byte decision logic.
// ----------------------------------------------------------------------------
module hwp_core import hwp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  logic    out_free_i,
  output logic    take_o,
  output result_t res_o
);

  localparam logic [1:0] PhStart = 2'd0;
  localparam logic [1:0] PhLine  = 2'd1;
  localparam logic [1:0] PhSkip  = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [27:0] acc_q, acc_d;
  logic        err_q, err_d;

  logic [7:0]  c;
  logic [4:0]  hx;
  logic        go;

  assign take_o = item_i.valid && out_free_i;
  assign c      = item_i.beat.char_byte;
  assign hx     = hex_decode(c);

  // next state and result for the held byte
  always_comb begin
    phase_d          = phase_q;
    cnt_d            = cnt_q;
    acc_d            = acc_q;
    err_d            = err_q;
    go               = 1'b0;
    res_o.valid      = 1'b0;
    res_o.beat.word  = 32'd0;
    res_o.beat.status = ST_WORD;

    if (!err_q) begin
      if (item_i.beat.end_of_data) begin
        if (cnt_q != 3'd0) begin
          res_o.valid       = 1'b1;
          res_o.beat.status = ST_INCOMPLETE;
        end else begin
          phase_d = PhStart;
        end
      end else if (phase_q == PhSkip) begin
        if (c == ChLf) begin
          phase_d = PhStart;
        end
      end else if (phase_q == PhStart) begin
        if (c == ChHash || c == ChNul) begin
          phase_d = PhSkip;
        end else if (c != ChLf) begin
          phase_d = PhLine;
          go      = 1'b1;
        end
      end else begin
        go = 1'b1;
      end

      if (go) begin
        if (c[7]) begin
          res_o.valid       = 1'b1;
          res_o.beat.status = ST_NON_ASCII;
        end else if (cnt_q != 3'd0) begin
          if (!hx[4]) begin
            res_o.valid       = 1'b1;
            res_o.beat.status = ST_INCOMPLETE;
          end else if (cnt_q == 3'd7) begin
            res_o.valid     = 1'b1;
            res_o.beat.word = {acc_q, hx[3:0]};
            cnt_d           = 3'd0;
            acc_d           = 28'd0;
          end else begin
            acc_d = {acc_q[23:0], hx[3:0]};
            cnt_d = cnt_q + 3'd1;
          end
        end else if (hx[4]) begin
          acc_d = {24'd0, hx[3:0]};
          cnt_d = 3'd1;
        end else if (is_blank(c)) begin
          // skip blank
        end else if (c == ChLf) begin
          phase_d = PhStart;
        end else if (c == ChNul) begin
          phase_d = PhSkip;
        end else begin
          res_o.valid       = 1'b1;
          res_o.beat.status = ST_INVALID;
        end
      end

      // any error result latches and clears the word
      if (res_o.valid && res_o.beat.status != ST_WORD) begin
        err_d = 1'b1;
        cnt_d = 3'd0;
        acc_d = 28'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      cnt_q   <= 3'd0;
      acc_q   <= 28'd0;
      err_q   <= 1'b0;
    end else if (take_o) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      err_q   <= err_d;
    end
  end

endmodule

[hdl/hwp_out_reg.sv]
// ----------------------------------------------------------------------------
// hwp_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module hwp_out_reg import hwp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  result_t   res_i,
  output logic      out_free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic      valid_q, valid_d;
  out_beat_t beat_q;
  logic      load;

  assign out_free_o = !valid_q || !out_stall_i;
  assign load       = take_i && res_i.valid;

  // new result, drained beat, or hold
  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= res_i.beat;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

endmodule

[hdl/hex_word_text_parser_top.sv]
// ----------------------------------------------------------------------------
// hex_word_text_parser_top
// Parses ASCII text into 32-bit words of eight hex digits each.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_stall_o   in_beat_i  (char_byte, end_of_data)
//   out      source     out_valid_o / out_stall_i out_beat_o (word, status)
//
// One byte per cycle sustained while the output is not stalled; a beat is held in the input
// register and its result, if any, is registered in the result register when the core takes it.
// The per-byte decision is a single pass of decode and shift in the core.
// Reset clears the line phase, digit count, word and error flag.
// A stalled result does not block input while the input register is empty.
// ----------------------------------------------------------------------------
module hex_word_text_parser_top import hwp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  item_t   item;
  result_t res;
  logic    take;
  logic    out_free;

  // input register
  hwp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .take_i     (take),
    .item_o     (item)
  );

  // parser state and decision
  hwp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .out_free_i (out_free),
    .take_o     (take),
    .res_o      (res)
  );

  // result register
  hwp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

[dv/tb_hex_word_text_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_word_text_parser_top
// Feeds text through the hex word parser: a few hand-picked lines first, then
// random well-formed lines of words, comments, blanks and skipped tails, and
// a final broken line that raises the one error the block reports before it
// falls silent. A local parser predicts each result; the monitor compares
// every output beat with the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_hex_word_text_parser_top;
  import hwp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 300;

  typedef enum logic [1:0] {
    PH_LINE_START,
    PH_IN_LINE,
    PH_SKIP_LINE
  } line_phase_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  hex_word_text_parser_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  // text beats waiting to be sent, parse results waiting to come out
  in_beat_t  text_q[$];
  out_beat_t parsed_q[$];

  // local parser state
  line_phase_e phase        = PH_LINE_START;
  int unsigned held_digits  = 0;
  logic [27:0] partial_word = '0;
  bit          error_seen   = 1'b0;

  int unsigned fail_count  = 0;
  int unsigned beats_taken = 0;
  int unsigned cycle_count = 0;
  logic        in_fire     = 1'b0;
  logic        out_fire    = 1'b0;
  out_beat_t   want;

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // hex value of a byte, or -1
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h37);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h57);
    return -1;
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == ChSpc || c == ChHt || c == ChVt || c == ChFf || c == ChCr;
  endfunction

  function automatic void emit(input logic [31:0] w, input status_e s);
    out_beat_t r;
    r.word   = w;
    r.status = s;
    parsed_q.push_back(r);
  endfunction

  function automatic void raise_error(input status_e s);
    error_seen   = 1'b1;
    held_digits  = 0;
    partial_word = '0;
    emit('0, s);
  endfunction

  // advance the local parser by one beat
  function automatic void parse_char(input in_beat_t b);
    int d;
    d = nibble_of(b.char_byte);
    if (error_seen) return;
    if (b.end_of_data) begin
      if (held_digits != 0) raise_error(ST_INCOMPLETE);
      else phase = PH_LINE_START;
      return;
    end
    if (phase == PH_SKIP_LINE) begin
      if (b.char_byte == ChLf) phase = PH_LINE_START;
      return;
    end
    if (phase == PH_LINE_START) begin
      if (b.char_byte == ChHash || b.char_byte == ChNul) begin
        phase = PH_SKIP_LINE;
        return;
      end
      if (b.char_byte == ChLf) return;
      phase = PH_IN_LINE;
    end
    if (b.char_byte[7]) begin
      raise_error(ST_NON_ASCII);
      return;
    end
    // inside a word only a digit may follow
    if (held_digits != 0) begin
      if (d < 0) begin
        raise_error(ST_INCOMPLETE);
      end else if (held_digits == 7) begin
        emit({partial_word, d[3:0]}, ST_WORD);
        held_digits  = 0;
        partial_word = '0;
      end else begin
        partial_word = {partial_word[23:0], d[3:0]};
        held_digits++;
      end
      return;
    end
    // between words
    if (d >= 0) begin
      partial_word = 28'(d);
      held_digits  = 1;
    end else if (is_space(b.char_byte)) begin
      return;
    end else if (b.char_byte == ChLf) begin
      phase = PH_LINE_START;
    end else if (b.char_byte == ChNul) begin
      phase = PH_SKIP_LINE;
    end else begin
      raise_error(ST_INVALID);
    end
  endfunction

  // stimulus builders
  function automatic void push_char(input logic [7:0] c);
    in_beat_t b;
    b.char_byte   = c;
    b.end_of_data = 1'b0;
    text_q.push_back(b);
  endfunction

  function automatic void push_eod();
    in_beat_t b;
    b.char_byte   = 8'($urandom_range(0, 255));
    b.end_of_data = 1'b1;
    text_q.push_back(b);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) != 0 ? 8'h37 : 8'h57) + 8'(v);
  endfunction

  function automatic void push_word(input logic [31:0] w);
    for (int i = 7; i >= 0; i--) push_char(hex_char(w[i*4 +: 4]));
  endfunction

  function automatic void push_digits(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_char(hex_char(4'($urandom_range(0, 15))));
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 4))
      0: return ChHt;
      1: return ChVt;
      2: return ChFf;
      3: return ChCr;
      default: return ChSpc;
    endcase
  endfunction

  // any byte but LF, for skipped text
  function automatic logic [7:0] junk_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == ChLf) ? 8'h8A : c;
  endfunction

  function automatic void gen_comment_line();
    push_char($urandom_range(0, 1) != 0 ? ChHash : ChNul);
    repeat ($urandom_range(0, 12)) push_char(junk_byte());
    if ($urandom_range(0, 5) == 0) push_eod();
    else push_char(ChLf);
  endfunction

  function automatic void gen_data_line();
    int unsigned n_words;
    n_words = $urandom_range(1, 5);
    repeat ($urandom_range(0, 2)) push_char(rand_blank());
    for (int unsigned i = 0; i < n_words; i++) begin
      push_word(pick_word());
      if (i != n_words - 1) begin
        if ($urandom_range(0, 11) == 0) push_eod();
        else repeat ($urandom_range(0, 3)) push_char(rand_blank());
      end
    end
    repeat ($urandom_range(0, 2)) push_char(rand_blank());
    // line end: NUL with skipped tail, end of data, or LF
    case ($urandom_range(0, 9))
      0: begin
        push_char(ChNul);
        repeat ($urandom_range(0, 6)) push_char(junk_byte());
        push_char(ChLf);
      end
      1: push_eod();
      default: push_char(ChLf);
    endcase
  endfunction

  // one broken line that ends the block's output
  function automatic void gen_error_line();
    logic [7:0] c;
    push_char(ChLf);
    case ($urandom_range(0, 4))
      0: begin
        push_word(pick_word());
        push_char(ChSpc);
        push_char(8'($urandom_range(128, 255)));
      end
      1: begin
        push_digits($urandom_range(1, 7));
        push_char(8'($urandom_range(128, 255)));
      end
      2: begin
        push_digits($urandom_range(1, 7));
        case ($urandom_range(0, 3))
          0: push_char(rand_blank());
          1: push_char(ChLf);
          2: push_char(ChNul);
          default: push_char(8'h67);
        endcase
      end
      3: begin
        push_digits($urandom_range(1, 7));
        push_eod();
      end
      default: begin
        c = 8'($urandom_range(1, 127));
        while (nibble_of(c) >= 0 || is_space(c) || c == ChLf) c = 8'($urandom_range(1, 127));
        push_word(pick_word());
        push_char(ChSpc);
        push_char(c);
      end
    endcase
    // everything after the error is dropped by the block
    repeat (20) begin
      if ($urandom_range(0, 7) == 0) push_eod();
      else push_char(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic int unsigned draw_wait(input bit fast);
    return fast ? 0 : $urandom_range(0, 7);
  endfunction

  // sender: offers the next beat at the falling edge, holds it while stalled
  int unsigned send_wait = 0;
  bit          send_fast = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (in_valid_i) begin
        if ($urandom_range(0, 31) == 0) send_fast = !send_fast;
        send_wait = draw_wait(send_fast);
      end
      if (send_wait == 0 && text_q.size() != 0) begin
        in_beat_i  <= text_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
        if (send_wait != 0) send_wait--;
      end
    end
  end

  // receiver: random stall per result, plus one long hold-off mid-run
  int unsigned rcv_wait  = 0;
  bit          rcv_fast  = 1'b0;
  bit          held_long = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        if ($urandom_range(0, 31) == 0) rcv_fast = !rcv_fast;
        rcv_wait = draw_wait(rcv_fast);
      end
      if (!held_long && beats_taken >= 400) begin
        held_long = 1'b1;
        rcv_wait  = LONG_HOLD;
      end
      if (rcv_wait != 0) begin
        out_stall_i <= 1'b1;
        rcv_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor: check output beats first, then predict from the input beat
  always @(posedge clk_i) begin
    out_fire <= rst_ni && out_valid_o && !out_stall_i;
    in_fire  <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (parsed_q.size() == 0) begin
        $error("result with nothing pending: word %h status %0d",
               out_beat_o.word, out_beat_o.status);
        fail_count++;
      end else begin
        want = parsed_q.pop_front();
        if (out_beat_o.word !== want.word) begin
          $error("word mismatch: expected %h, got %h", want.word, out_beat_o.word);
          fail_count++;
        end
        if (out_beat_o.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_beat_o.status);
          fail_count++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      parse_char(in_beat_i);
      beats_taken++;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    // comment line holding non-ascii and NUL
    push_char(ChHash);
    push_char(8'hFF);
    push_char(ChNul);
    push_char(ChLf);
    // empty line
    push_char(ChLf);
    // NUL-led line closed by end of data
    push_char(ChNul);
    push_char(8'h80);
    push_eod();
    // every blank, then an all-ones word, LF, end of data at line start
    push_char(ChHt);
    push_char(ChVt);
    push_char(ChFf);
    push_char(ChCr);
    push_char(ChSpc);
    push_word(32'hFFFF_FFFF);
    push_char(ChLf);
    push_eod();

    // random lines, mostly words
    while (text_q.size() < 1020) begin
      case ($urandom_range(0, 9))
        0: gen_comment_line();
        1: begin
          repeat ($urandom_range(0, 2)) push_char(rand_blank());
          push_char(ChLf);
        end
        default: gen_data_line();
      endcase
    end
    gen_error_line();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
